>>> hw/rtl/secr_pkg.sv
// ----------------------------------------------------------------------------
// secr_pkg
// Shared types, constants and helpers for the serial expansion channel
// register bank.
// ----------------------------------------------------------------------------
package secr_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int CHAN_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int DATA_W = 32;
  localparam int OFFS_W = 8;
  localparam int SIZE_W = 2;

  // Byte stride between channel register groups.
  localparam int CHAN_STRIDE = 'h14;

  // Register offsets within one channel group.
  localparam logic [OFFS_W-1:0] OFFS_STATUS    = 8'h00;
  localparam logic [OFFS_W-1:0] OFFS_DMA_ADDR  = 8'h04;
  localparam logic [OFFS_W-1:0] OFFS_DMA_LEN   = 8'h08;
  localparam logic [OFFS_W-1:0] OFFS_CONTROL   = 8'h0C;
  localparam logic [OFFS_W-1:0] OFFS_IMMEDIATE = 8'h10;

  // Access size codes.
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

  // Opcodes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Status bit fields.
  localparam logic [DATA_W-1:0] ST_XFER_DONE = 32'h0000_0008;
  localparam logic [DATA_W-1:0] ST_W1C       = 32'h0000_080A;  // bits 1, 3, 11
  localparam logic [DATA_W-1:0] ST_WRITABLE  = 32'h0000_27F5;  // 0, 2, 4..10, 13
  localparam logic [DATA_W-1:0] ST_RST_CH0   = 32'h0000_0800;
  localparam logic [DATA_W-1:0] ST_RST_CH1   = 32'h0000_0880;

  localparam logic [DATA_W-1:0] IMM_FILL = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_STATUS,
    REG_DMA_ADDR,
    REG_DMA_LEN,
    REG_CONTROL,
    REG_IMMEDIATE,
    REG_NONE
  } reg_sel_t;

  // Write request routed to one channel.
  typedef struct packed {
    logic              en;
    reg_sel_t          sel;
    logic [DATA_W-1:0] data;
  } chan_wr_t;

  // Current contents of one channel.
  typedef struct packed {
    logic [DATA_W-1:0] status;
    logic [DATA_W-1:0] dma_addr;
    logic [DATA_W-1:0] dma_len;
    logic [DATA_W-1:0] control;
    logic [DATA_W-1:0] immediate;
  } chan_regs_t;

  function automatic logic [DATA_W-1:0] status_reset(input int c);
    logic [DATA_W-1:0] v;
    v = '0;
    if (c == 0) begin
      v = ST_RST_CH0;
    end else if (c == 1) begin
      v = ST_RST_CH1;
    end
    return v;
  endfunction

  // Interrupt when any enable-and-flag pair is set.
  function automatic logic status_irq(input logic [DATA_W-1:0] s);
    return (s[0] & s[1]) | (s[2] & s[3]) | (s[10] & s[11]);
  endfunction

endpackage

>>> hw/rtl/secr_req_if.sv
// ----------------------------------------------------------------------------
// secr_req_if
// Request channel: one bus access per beat.
// ----------------------------------------------------------------------------
interface secr_req_if;
  import secr_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [OFFS_W-1:0] offset;
  logic [SIZE_W-1:0] access_size;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, opcode, offset, access_size, write_data, input ready);
  modport sink   (input valid, opcode, offset, access_size, write_data, output ready);
endinterface

>>> hw/rtl/secr_rsp_if.sv
// ----------------------------------------------------------------------------
// secr_rsp_if
// Response channel: read data and interrupt level, one beat per access.
// ----------------------------------------------------------------------------
interface secr_rsp_if;
  import secr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq;

  modport source (output valid, read_data, irq, input ready);
  modport sink   (input valid, read_data, irq, output ready);
endinterface

>>> hw/rtl/secr_chan.sv
// ----------------------------------------------------------------------------
// secr_chan
// Register group of one channel: status, DMA address/length, control,
// immediate data. Reports its interrupt term for the state after a write.
// ----------------------------------------------------------------------------
module secr_chan (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [secr_pkg::DATA_W-1:0]       reset_status,
  input  secr_pkg::chan_wr_t                wr,
  output secr_pkg::chan_regs_t              regs,
  output logic                              irq_next
);
  import secr_pkg::*;

  chan_regs_t regs_next;
  logic       start;

  assign start = wr.data[0];

  always_comb begin
    regs_next = regs;
    if (wr.en) begin
      case (wr.sel)
        REG_STATUS: begin
          regs_next.status = ((regs.status & ~(wr.data & ST_W1C)) & ~ST_WRITABLE)
                           | (wr.data & ST_WRITABLE);
        end
        REG_DMA_ADDR:  regs_next.dma_addr  = wr.data;
        REG_DMA_LEN:   regs_next.dma_len   = wr.data;
        REG_CONTROL: begin
          regs_next.control = {wr.data[DATA_W-1:1], 1'b0};
          if (!start) begin
            regs_next.control[0] = wr.data[0];
          end else begin
            regs_next.status = regs.status | ST_XFER_DONE;
            // immediate-read mode: dir bit and mode bits all zero
            if (wr.data[3:1] == 3'b000) begin
              regs_next.immediate = IMM_FILL;
            end
          end
        end
        REG_IMMEDIATE: regs_next.immediate = wr.data;
        default: ;
      endcase
    end
  end

  assign irq_next = status_irq(regs_next.status);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.status    <= reset_status;
      regs.dma_addr  <= '0;
      regs.dma_len   <= '0;
      regs.control   <= '0;
      regs.immediate <= '0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

>>> hw/rtl/serial_expansion_channel_registers_core.sv
// ----------------------------------------------------------------------------
// serial_expansion_channel_registers_core
// Register bank for the serial expansion channels, one bus access per beat.
// ----------------------------------------------------------------------------
// Each channel owns five word registers at 0x14-byte spacing: status (+0x00),
// DMA address (+0x04), DMA length (+0x08), control (+0x0C) and immediate data
// (+0x10). Only word accesses act; byte/halfword accesses, gap offsets and
// offsets past the last channel read zero and write nothing. Writes always
// return zero read data. Every access returns one response beat carrying the
// interrupt level as it stands after that access. The block takes one access
// per clock cycle unless the response register stalls: an access is captured
// in the request register, is decoded and applied there, and its response is
// held in the response register. A stalled response register stops the
// request register, which then accepts nothing until it drains. Status bits
// 1, 3 and 11 are write-one-to-clear; a control write with the start bit sets
// transfer-complete (status bit 3) and reads back with start cleared.
// ----------------------------------------------------------------------------
module serial_expansion_channel_registers_core (
  input logic       clk,
  input logic       rst,
  secr_req_if.sink  req,
  secr_rsp_if.source rsp
);
  import secr_pkg::*;

  // Request register.
  logic              s1_valid;
  logic              s1_opcode;
  logic [OFFS_W-1:0] s1_offset;
  logic [SIZE_W-1:0] s1_access_size;
  logic [DATA_W-1:0] s1_write_data;

  // Response register.
  logic              out_valid;
  logic [DATA_W-1:0] out_read_data;
  logic              out_irq;

  logic s1_advance;

  // Decode.
  logic [NUM_CHANNELS-1:0] hit;
  logic [CHAN_W-1:0]       chan_idx;
  logic [OFFS_W-1:0]       reg_offs;
  reg_sel_t                sel;
  logic                    is_word;
  logic                    act;

  chan_wr_t                wr     [NUM_CHANNELS];
  chan_regs_t              regs   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] irq_vec;

  logic [DATA_W-1:0] read_data_next;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_opcode      <= req.opcode;
      s1_offset      <= req.offset;
      s1_access_size <= req.access_size;
      s1_write_data  <= req.write_data;
    end
  end

  // Channel range compare: one comparator pair per channel, bounds fixed.
  always_comb begin
    chan_idx = '0;
    reg_offs = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      hit[c] = ({1'b0, s1_offset} >= 9'(c * CHAN_STRIDE))
            && ({1'b0, s1_offset} <  9'((c + 1) * CHAN_STRIDE));
      if (hit[c]) begin
        chan_idx = CHAN_W'(c);
        reg_offs = s1_offset - OFFS_W'(c * CHAN_STRIDE);
      end
    end
  end

  always_comb begin
    case (reg_offs)
      OFFS_STATUS:    sel = REG_STATUS;
      OFFS_DMA_ADDR:  sel = REG_DMA_ADDR;
      OFFS_DMA_LEN:   sel = REG_DMA_LEN;
      OFFS_CONTROL:   sel = REG_CONTROL;
      OFFS_IMMEDIATE: sel = REG_IMMEDIATE;
      default:        sel = REG_NONE;
    endcase
  end

  assign is_word = (s1_access_size == SIZE_WORD);
  assign act     = is_word && (|hit) && (sel != REG_NONE);

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    assign wr[c].en   = s1_advance && act && hit[c] && (s1_opcode == OP_WRITE);
    assign wr[c].sel  = sel;
    assign wr[c].data = s1_write_data;

    secr_chan u_chan (
      .clk          (clk),
      .rst          (rst),
      .reset_status (status_reset(c)),
      .wr           (wr[c]),
      .regs         (regs[c]),
      .irq_next     (irq_vec[c])
    );
  end

  // Read mux; reads see the state left by all earlier accesses.
  always_comb begin
    read_data_next = '0;
    if (act && (s1_opcode == OP_READ)) begin
      case (sel)
        REG_STATUS:    read_data_next = regs[chan_idx].status;
        REG_DMA_ADDR:  read_data_next = regs[chan_idx].dma_addr;
        REG_DMA_LEN:   read_data_next = regs[chan_idx].dma_len;
        REG_CONTROL:   read_data_next = regs[chan_idx].control;
        REG_IMMEDIATE: read_data_next = regs[chan_idx].immediate;
        default:       read_data_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_read_data <= read_data_next;
      out_irq       <= |irq_vec;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_read_data;
  assign rsp.irq       = out_irq;

`ifndef SYNTHESIS
  // A write beat never returns data.
  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    s1_advance && (s1_opcode == OP_WRITE) |=> out_read_data == '0)
    else $error("write access returned nonzero read data");

  // Non-word accesses return zero.
  a_size_reads_zero: assert property (@(posedge clk) disable iff (rst)
    s1_advance && (s1_access_size != SIZE_WORD) |=> out_read_data == '0)
    else $error("non-word access returned nonzero read data");

  // An offset falls in at most one channel window.
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(hit))
    else $error("offset decoded to more than one channel");

  // An empty response register never blocks requests.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> req.ready)
    else $error("request stalled with empty response register");
`endif

endmodule
